/* design/salru_pkg.sv */
// shared types, codes and constants of the set-associative lru cache lookup
// no dependencies
`default_nettype none

package salru_pkg;

  localparam int ADDR_W        = 64;
  localparam int STAMP_W       = 64;
  localparam int TALLY_W       = 32;
  localparam int SET_BITS_W    = 3;
  localparam int OFFSET_BITS_W = 6;
  localparam int WAYS_W        = 4;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 8;
  localparam int OFFSET_MAX    = 32;

  localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = SET_BITS_W'(1);
  localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = OFFSET_BITS_W'(4);
  localparam logic [WAYS_W-1:0]        WAYS_RST        = WAYS_W'(1);
  localparam logic [STAMP_W-1:0]       STAMP_RST       = STAMP_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS    = 8'd0,
    REG_OFFSET_BITS = 8'd1,
    REG_WAYS_IN_USE = 8'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef struct packed {
    logic accept;
    logic look;
    logic scan;
    logic commit;
  } salru_cmd_t;

  typedef struct packed {
    logic hit;
    logic single_way;
    logic scan_last;
    logic out_free;
  } salru_status_t;

  function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
    return (v == {TALLY_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

/* design/salru_if.sv */
// handshake channels of the lru cache lookup: access, result and config write
// depends on salru_pkg
`default_nettype none

interface salru_acc_if import salru_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface salru_res_if import salru_pkg::*; ();
  logic               valid;
  logic               ready;
  outcome_e           outcome;
  logic [TALLY_W-1:0] hits_total;
  logic [TALLY_W-1:0] misses_total;
  logic [TALLY_W-1:0] evictions_total;

  modport source (output valid, output outcome, output hits_total, output misses_total,
                  output evictions_total, input ready);
  modport sink (input valid, input outcome, input hits_total, input misses_total,
                input evictions_total, output ready);
endinterface

interface salru_cfg_if import salru_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/salru_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module salru_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]                       wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [DATA_W-1:0]                       rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/salru_ctrl.sv */
// sequencing state machine: accept, set lookup, victim scan, write-back
// depends on salru_pkg
`default_nettype none

module salru_ctrl import salru_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          acc_valid_i,
  output logic               acc_ready_o,
  input  wire salru_status_t status_i,
  output salru_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOOK  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc_valid_i) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (status_i.hit || status_i.single_way) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign acc_ready_o   = (state_q == ST_IDLE);
  assign cmd_o.accept  = (state_q == ST_IDLE) && acc_valid_i;
  assign cmd_o.look    = (state_q == ST_LOOK);
  assign cmd_o.scan    = (state_q == ST_SCAN);
  assign cmd_o.commit  = (state_q == ST_WRITE) && status_i.out_free;

endmodule

`default_nettype wire

/* design/salru_dp.sv */
// datapath: config registers, address split, set memory, tag match,
// lru victim scan, tallies and result register; depends on salru_pkg, salru_ram
`default_nettype none

module salru_dp import salru_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8,
  parameter int ADDRESS_BITS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [ADDR_W-1:0]     address_i,
  input  wire salru_cmd_t            cmd_i,
  output salru_status_t              status_o,
  input  wire logic                  res_ready_i,
  output logic                       res_valid_o,
  output outcome_e                   outcome_o,
  output logic [TALLY_W-1:0]         hits_total_o,
  output logic [TALLY_W-1:0]         misses_total_o,
  output logic [TALLY_W-1:0]         evictions_total_o
);

  localparam int NUM_SETS = 2 ** MAX_SET_BITS;
  localparam int TAG_W    = ADDRESS_BITS - 2;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCNT_W   = $clog2(WAYS + 1);
  localparam int SB_W     = $clog2(MAX_SET_BITS + 1);
  localparam int SHAMT_W  = $clog2(MAX_SET_BITS + OFFSET_MAX + 1);
  localparam int ROW_W    = WAYS * (1 + TAG_W + STAMP_W);

  // configuration
  logic [SET_BITS_W-1:0]    set_bits_q;
  logic [OFFSET_BITS_W-1:0] offset_bits_q;
  logic [WAYS_W-1:0]        ways_q;
  logic [SB_W-1:0]          sb_eff;
  logic [OFFSET_BITS_W-1:0] ob_eff;
  logic [WCNT_W-1:0]        ways_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q    <= SET_BITS_RST;
      offset_bits_q <= OFFSET_BITS_RST;
      ways_q        <= WAYS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SET_BITS:    set_bits_q    <= cfg_data_i[SET_BITS_W-1:0];
        REG_OFFSET_BITS: offset_bits_q <= cfg_data_i[OFFSET_BITS_W-1:0];
        REG_WAYS_IN_USE: ways_q        <= cfg_data_i[WAYS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (set_bits_q == '0) begin
      sb_eff = SB_W'(1);
    end else if (32'(set_bits_q) > MAX_SET_BITS) begin
      sb_eff = SB_W'(MAX_SET_BITS);
    end else begin
      sb_eff = SB_W'(set_bits_q);
    end
    if (offset_bits_q == '0) begin
      ob_eff = OFFSET_BITS_W'(1);
    end else if (32'(offset_bits_q) > OFFSET_MAX) begin
      ob_eff = OFFSET_BITS_W'(OFFSET_MAX);
    end else begin
      ob_eff = offset_bits_q;
    end
    if (ways_q == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (32'(ways_q) > WAYS) begin
      ways_eff = WCNT_W'(WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_q);
    end
  end

  // address split
  logic [ADDRESS_BITS-1:0] addr_m;
  logic [MAX_SET_BITS-1:0] set_mask;
  logic [MAX_SET_BITS-1:0] set_d;
  logic [TAG_W-1:0]        tag_d;

  assign addr_m   = address_i[ADDRESS_BITS-1:0];
  assign set_mask = ~({MAX_SET_BITS{1'b1}} << sb_eff);
  assign set_d    = MAX_SET_BITS'(addr_m >> ob_eff) & set_mask;
  assign tag_d    = TAG_W'(addr_m >> (SHAMT_W'(sb_eff) + SHAMT_W'(ob_eff)));

  logic [MAX_SET_BITS-1:0] acc_set_q;
  logic [TAG_W-1:0]        acc_tag_q;
  logic                    rowv_q;
  logic [NUM_SETS-1:0]     set_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      acc_set_q <= set_d;
      acc_tag_q <= tag_d;
      rowv_q    <= set_vld_q[set_d];
    end
  end

  // set memory, one row per set holding all ways
  logic [ROW_W-1:0] rdata;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wdata;

  salru_ram #(
    .DATA_W (ROW_W),
    .DEPTH  (NUM_SETS)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (acc_set_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (set_d),
    .rdata_o (rdata)
  );

  // a set never written reads as all zero
  assign rd_row = rdata & {ROW_W{rowv_q}};

  logic [WAYS-1:0]              rd_vld;
  logic [WAYS-1:0][TAG_W-1:0]   rd_tag;
  logic [WAYS-1:0][STAMP_W-1:0] rd_stamp;

  assign {rd_stamp, rd_tag, rd_vld} = rd_row;

  // tag match, lowest way first
  logic             hit_any;
  logic [WAY_W-1:0] hit_way;

  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_vld[w] && (rd_tag[w] == acc_tag_q) && (WCNT_W'(w) < ways_eff)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // row copy and victim scan
  logic [WAYS-1:0]              row_vld_q;
  logic [WAYS-1:0][TAG_W-1:0]   row_tag_q;
  logic [WAYS-1:0][STAMP_W-1:0] row_stamp_q;
  logic                         hit_q;
  logic [WAY_W-1:0]             hit_way_q;
  logic [WAY_W-1:0]             victim_q;
  logic [WAY_W-1:0]             cnt_q;
  logic [STAMP_W-1:0]           min_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      row_vld_q   <= rd_vld;
      row_tag_q   <= rd_tag;
      row_stamp_q <= rd_stamp;
      hit_q       <= hit_any;
      hit_way_q   <= hit_way;
      victim_q    <= '0;
      min_q       <= rd_stamp[0];
      cnt_q       <= WAY_W'(1);
    end else if (cmd_i.scan) begin
      if (row_stamp_q[cnt_q] < min_q) begin
        min_q    <= row_stamp_q[cnt_q];
        victim_q <= cnt_q;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // write-back row
  logic [WAY_W-1:0]             sel_way;
  logic [WAYS-1:0]              nw_vld;
  logic [WAYS-1:0][TAG_W-1:0]   nw_tag;
  logic [WAYS-1:0][STAMP_W-1:0] nw_stamp;
  logic [STAMP_W-1:0]           access_stamp_q;
  logic                         evict;

  always_comb begin
    sel_way  = hit_q ? hit_way_q : victim_q;
    nw_vld   = row_vld_q;
    nw_tag   = row_tag_q;
    nw_stamp = row_stamp_q;
    nw_stamp[sel_way] = access_stamp_q;
    if (!hit_q) begin
      nw_vld[sel_way] = 1'b1;
      nw_tag[sel_way] = acc_tag_q;
    end
  end

  assign wdata = {nw_stamp, nw_tag, nw_vld};
  assign evict = !hit_q && row_vld_q[victim_q];

  // tallies, stamp counter, result
  logic [TALLY_W-1:0] hit_tally_q;
  logic [TALLY_W-1:0] miss_tally_q;
  logic [TALLY_W-1:0] evict_tally_q;
  logic               res_valid_q;
  outcome_e           outcome_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_vld_q      <= '0;
      access_stamp_q <= STAMP_RST;
      hit_tally_q    <= '0;
      miss_tally_q   <= '0;
      evict_tally_q  <= '0;
      res_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        set_vld_q[acc_set_q] <= 1'b1;
        access_stamp_q       <= access_stamp_q + 1'b1;
        if (hit_q) begin
          hit_tally_q <= sat_inc(hit_tally_q);
        end else begin
          miss_tally_q <= sat_inc(miss_tally_q);
        end
        if (evict) begin
          evict_tally_q <= sat_inc(evict_tally_q);
        end
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (hit_q) begin
        outcome_q <= OUT_HIT;
      end else if (evict) begin
        outcome_q <= OUT_EVICT;
      end else begin
        outcome_q <= OUT_FILL;
      end
    end
  end

  assign status_o.hit        = hit_any;
  assign status_o.single_way = (ways_eff == WCNT_W'(1));
  assign status_o.scan_last  = (WCNT_W'(cnt_q) == (ways_eff - WCNT_W'(1)));
  assign status_o.out_free   = !res_valid_q || res_ready_i;

  assign res_valid_o       = res_valid_q;
  assign outcome_o         = outcome_q;
  assign hits_total_o      = hit_tally_q;
  assign misses_total_o    = miss_tally_q;
  assign evictions_total_o = evict_tally_q;

endmodule

`default_nettype wire

/* design/set_assoc_cache_lru_lookup.sv */
// set-associative cache lookup with lru replacement, top level
// a hit, or a single way in use, goes from the set lookup straight to write-back; otherwise
// the victim scan runs first, one way per cycle through a shared 64-bit comparator; write-back
// waits until the result channel is free, and no new address is accepted before it commits
// reset: async active low; per-set valid flops clear at once, no memory clearing pass
// depends on salru_pkg, salru_if, salru_ram, salru_ctrl, salru_dp
`default_nettype none

module set_assoc_cache_lru_lookup import salru_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8,
  parameter int ADDRESS_BITS = 64
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  salru_acc_if.sink  acc_i,
  salru_res_if.source res_o,
  salru_cfg_if.sink  cfg_i
);

  salru_cmd_t    cmd;
  salru_status_t status;
  logic          cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  salru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_valid_i (acc_i.valid),
    .acc_ready_o (acc_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  salru_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .WAYS         (WAYS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .address_i         (acc_i.address),
    .cmd_i             (cmd),
    .status_o          (status),
    .res_ready_i       (res_o.ready),
    .res_valid_o       (res_o.valid),
    .outcome_o         (res_o.outcome),
    .hits_total_o      (res_o.hits_total),
    .misses_total_o    (res_o.misses_total),
    .evictions_total_o (res_o.evictions_total)
  );

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.look, cmd.scan, cmd.commit}))
    else $error("more than one datapath command at once");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i.valid && acc_i.ready) |=> !acc_i.ready)
    else $error("address taken while a transaction is in flight");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(cmd.commit))
    else $error("result raised without a write-back");

endmodule

`default_nettype wire
